@@ src/i2cwom_pkg.sv @@
// Shared types and constants for the write-only two-wire master sequencer.
// No dependencies; the front, queue, back and top level import this package.
package i2cwom_pkg;

    // Request codes as they arrive on the input channel
    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_STOP  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    // Sequencer phases in the back part
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_START = 2'd1,
        PH_BYTE  = 2'd2,
        PH_STOP  = 2'd3
    } phase_t;

    // One classified job between front and back
    typedef struct packed {
        req_t       kind;
        logic [7:0] byte_val;
        logic       last;
    } job_t;

    // Queue geometry
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Byte phase: eight data bits then the acknowledge slot
    localparam logic [3:0] ACK_SLOT  = 4'd8;
    localparam logic [1:0] SUB_LAST  = 2'd2;
    localparam logic [1:0] STOP_LAST = 2'd3;

    // Queue status seen by the back part
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

@@ src/i2cwom_front.sv @@
// Front part: holds the address register, classifies requests into jobs.
// Depends on i2cwom_pkg.
module i2cwom_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,
    input  logic               s_tlast,
    input  logic [1:0]         s_tuser,
    input  logic               q_full,
    output logic               q_push,
    output i2cwom_pkg::job_t   q_job
);
    import i2cwom_pkg::*;

    logic [7:0] addr_reg;
    req_t       kind;

    // Hold the configured address byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg <= 8'h00;
        end else if (cfg_we) begin
            addr_reg <= cfg_wdata;
        end
    end

    // Classify: a start sends the address, unknown codes are dropped
    always_comb begin
        kind           = req_t'(s_tuser);
        s_tready       = !q_full;
        q_push         = s_tvalid && !q_full && (kind != REQ_NONE);
        q_job.kind     = kind;
        q_job.byte_val = (kind == REQ_START) ? addr_reg : s_tdata;
        q_job.last     = (kind == REQ_WRITE) ? s_tlast : 1'b0;
    end

endmodule

@@ src/i2cwom_fifo.sv @@
// Short job queue between the front and back parts.
// Depends on i2cwom_pkg for the job type and depth constants.
module i2cwom_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  i2cwom_pkg::job_t      push_job,
    input  logic                  pop,
    output i2cwom_pkg::job_t      head_job,
    output i2cwom_pkg::q_status_t status
);
    import i2cwom_pkg::*;

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    // Advance pointers and fill count
    always_comb begin
        do_push     = push && (cnt_reg != QCNT_W'(QDEPTH));
        do_pop      = pop && (cnt_reg != '0);
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store entries; payload needs no reset
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head_job     = mem_reg[rd_ptr_reg];
    assign status.empty = (cnt_reg == '0);
    assign status.full  = (cnt_reg == QCNT_W'(QDEPTH));

endmodule

@@ src/i2cwom_back.sv @@
// Back part: steps through line states for one job at a time into an output register.
// Depends on i2cwom_pkg.
module i2cwom_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  i2cwom_pkg::job_t      head_job,
    input  i2cwom_pkg::q_status_t q_status,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic                  m_tlast,
    output logic                  m_tuser
);
    import i2cwom_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [1:0] sub_reg, sub_next;
    logic [3:0] bit_reg, bit_next;
    logic [7:0] shift_reg, shift_next;
    logic       blk_reg, blk_next;
    logic       scl_reg, scl_next;
    logic       drv_reg, drv_next;

    logic       ov_reg, ov_next;
    logic [2:0] lines_reg, lines_next;
    logic       slast_reg, slast_next;
    logic       bdone_reg, bdone_next;

    logic       advance, emit, job_end;
    logic       e_scl, e_sda, e_drv;

    // Current step's line levels
    always_comb begin
        e_scl   = scl_reg;
        e_sda   = 1'b1;
        e_drv   = drv_reg;
        job_end = 1'b0;
        case (phase_reg)
            PH_START: begin
                e_drv = 1'b1;
                e_scl = (sub_reg != SUB_LAST);
                e_sda = (sub_reg == 2'd0);
            end
            PH_BYTE: begin
                e_scl   = (sub_reg == 2'd1);
                e_sda   = (bit_reg == ACK_SLOT) ? 1'b0 : shift_reg[7];
                job_end = (bit_reg == ACK_SLOT) && (sub_reg == SUB_LAST);
            end
            PH_STOP: begin
                e_scl   = (sub_reg == 2'd0) ? scl_reg : 1'b1;
                e_sda   = (sub_reg >= 2'd2);
                e_drv   = (sub_reg == STOP_LAST) ? 1'b0 : drv_reg;
                job_end = (sub_reg == STOP_LAST);
            end
            default: begin
                e_scl = scl_reg;
            end
        endcase
    end

    // Sequence steps, load the next job without a gap
    always_comb begin
        advance    = !ov_reg || m_tready;
        emit       = advance && (phase_reg != PH_IDLE);
        q_pop      = advance && ((phase_reg == PH_IDLE) || job_end) && !q_status.empty;
        phase_next = phase_reg;
        sub_next   = sub_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        blk_next   = blk_reg;
        scl_next   = scl_reg;
        drv_next   = drv_reg;
        ov_next    = ov_reg && !m_tready;
        lines_next = lines_reg;
        slast_next = slast_reg;
        bdone_next = bdone_reg;

        if (emit) begin
            ov_next    = 1'b1;
            lines_next = {e_drv, e_sda, e_scl};
            slast_next = job_end;
            bdone_next = job_end && blk_reg && (phase_reg == PH_BYTE);
            scl_next   = e_scl;
            drv_next   = e_drv;
            case (phase_reg)
                PH_START: begin
                    if (sub_reg == SUB_LAST) begin
                        phase_next = PH_BYTE;
                        sub_next   = 2'd0;
                        bit_next   = 4'd0;
                    end else begin
                        sub_next = sub_reg + 1'b1;
                    end
                end
                PH_BYTE: begin
                    if (sub_reg == SUB_LAST) begin
                        sub_next   = 2'd0;
                        bit_next   = bit_reg + 1'b1;
                        shift_next = {shift_reg[6:0], 1'b0};
                    end else begin
                        sub_next = sub_reg + 1'b1;
                    end
                end
                PH_STOP: begin
                    sub_next = sub_reg + 1'b1;
                end
                default: begin
                    sub_next = sub_reg;
                end
            endcase
            if (job_end) begin
                phase_next = PH_IDLE;
            end
        end

        if (q_pop) begin
            sub_next   = 2'd0;
            bit_next   = 4'd0;
            shift_next = head_job.byte_val;
            blk_next   = head_job.last;
            case (head_job.kind)
                REQ_START: phase_next = PH_START;
                REQ_WRITE: phase_next = PH_BYTE;
                REQ_STOP:  phase_next = PH_STOP;
                default:   phase_next = PH_IDLE;
            endcase
        end
    end

    // Control and line state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            sub_reg   <= 2'd0;
            bit_reg   <= 4'd0;
            scl_reg   <= 1'b1;
            drv_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            sub_reg   <= sub_next;
            bit_reg   <= bit_next;
            scl_reg   <= scl_next;
            drv_reg   <= drv_next;
            ov_reg    <= ov_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        blk_reg   <= blk_next;
        lines_reg <= lines_next;
        slast_reg <= slast_next;
        bdone_reg <= bdone_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {5'b0, lines_reg};
    assign m_tlast  = slast_reg;
    assign m_tuser  = bdone_reg;

endmodule

@@ src/i2c_write_only_master_sequencer_unit.sv @@
// Top level of the write-only two-wire master sequencer: front, queue, back.
// Depends on i2cwom_pkg, i2cwom_front, i2cwom_fifo and i2cwom_back.
//
// Channel | Dir | Ports                         | Contents
// s_      | in  | s_tvalid/tready/tdata/tlast/tuser | request: tuser req_type, tdata byte, tlast
// m_      | out | m_tvalid/tready/tdata/tlast/tuser | one line step per item
// cfg_    | in  | cfg_we, cfg_wdata             | slave address byte
//
// One line step leaves per cycle unless m_tready stalls; a start sends start steps and the
// address byte, a write one byte and its ack slot, a stop its steps; jobs run back to back.
// A two-entry job queue lets requests be accepted while earlier ones are sent.
// From idle, a request crosses the job queue and phase register before its first output step.
// Reset (aresetn low, synchronous) releases the lines and clears the address byte.
// A stalled m_tready holds the output step and stops the sequencer.
module i2c_write_only_master_sequencer_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,
    input  logic [1:0] s_tuser,   // [1:0] req_type
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [0] scl_level, [1] sda_level, [2] lines_driven, [7:3] zero
    output logic       m_tlast,
    output logic       m_tuser    // [0] block_done
);
    import i2cwom_pkg::*;

    logic      q_push, q_pop;
    job_t      q_in, q_head;
    q_status_t q_status;

    i2cwom_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .q_full    (q_status.full),
        .q_push    (q_push),
        .q_job     (q_in)
    );

    i2cwom_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_in),
        .pop      (q_pop),
        .head_job (q_head),
        .status   (q_status)
    );

    i2cwom_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (q_head),
        .q_status (q_status),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

@@ src/i2cwom_checker.sv @@
// Port-level checks for the sequencer top level, attached by bind.
// Depends only on the top level's port list.
module i2cwom_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);

    // Hold a stalled output item
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("output item changed while stalled");

    // Block done only marks a request's final step
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("block_done without step_last");

    // Reset leaves no output item pending
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // Padding bits of the output data stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:3] == 5'b0))
        else $error("output padding not zero");

endmodule

bind i2c_write_only_master_sequencer_unit i2cwom_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
